FILE: rtl/pfrf_pkg.sv
`default_nettype none
package pfrf_pkg;

  localparam int FORCE_FRAC_BITS = 16;

  localparam int POS_W    = 20;
  localparam int OBS_W    = 12;
  localparam int DIFF_W   = 21;
  localparam int GAIN_W   = 32;
  localparam int RAD_W    = 20;
  localparam int FORCE_W  = 32;
  localparam int ALU_W    = 136;
  localparam int MULB_W   = 42;
  localparam int ROOT_W   = 41;
  localparam int D2_W     = 42;
  localparam int DEN_W    = 100;
  localparam int BASE_W   = 52;
  localparam int QUO_W    = 35;
  localparam int DIV_SH   = QUO_W - 1;
  localparam int NUM_SH   = FORCE_FRAC_BITS + 8;
  localparam int CNT_W    = 6;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN   = 1'b0,
    CFG_RADIUS = 1'b1
  } pfrf_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_CHK,
    ST_D2,
    ST_RD2,
    ST_DEN,
    ST_BASE,
    ST_NUM,
    ST_DIV,
    ST_TERM,
    ST_FIN
  } pfrf_state_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [RAD_W-1:0]  radius;
  } pfrf_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/pfrf_if.sv
`default_nettype none
interface pfrf_obs_if;
  logic                      valid;
  logic                      ready;
  logic signed [19:0]        vehicle_x;
  logic signed [19:0]        vehicle_y;
  logic signed [11:0]        obstacle_x;
  logic signed [11:0]        obstacle_y;
  logic                      obstacle_present;
  logic                      final_obstacle;
  modport source (output valid, vehicle_x, vehicle_y, obstacle_x, obstacle_y,
                  obstacle_present, final_obstacle, input ready);
  modport sink (input valid, vehicle_x, vehicle_y, obstacle_x, obstacle_y,
                obstacle_present, final_obstacle, output ready);
endinterface

interface pfrf_force_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic               force_saturated;
  logic               zero_distance_seen;
  modport source (output valid, force_x, force_y, force_saturated, zero_distance_seen,
                  input ready);
  modport sink (input valid, force_x, force_y, force_saturated, zero_distance_seen,
                output ready);
endinterface

interface pfrf_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pfrf_alu.sv
`default_nettype none
module pfrf_alu (
  input  wire logic [pfrf_pkg::ALU_W-1:0] a_i,
  input  wire logic [pfrf_pkg::ALU_W-1:0] b_i,
  input  wire logic                       sub_i,
  output logic      [pfrf_pkg::ALU_W-1:0] res_o,
  output logic                            carry_o
);
  import pfrf_pkg::*;

  logic [ALU_W-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign {carry_o, res_o} = {1'b0, a_i} + {1'b0, b_eff} + {{ALU_W{1'b0}}, sub_i};
endmodule
`default_nettype wire

FILE: rtl/pfrf_core.sv
`default_nettype none
module pfrf_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pfrf_pkg::pfrf_cfg_t cfg_i,
  pfrf_obs_if.sink                obs_i,
  pfrf_force_if.source            force_o
);
  import pfrf_pkg::*;

  pfrf_state_e state_q, state_d;
  logic [ALU_W-1:0]  acc_q, acc_d, ma_q, ma_d;
  logic [MULB_W-1:0] mb_q, mb_d;
  logic [ROOT_W-1:0] res_q, res_d, bit_q, bit_d, rb;
  logic [DIFF_W-1:0] magx_q, magx_d, magy_q, magy_d, d_q, d_d;
  logic              negx_q, negx_d, negy_q, negy_d, comp_q, comp_d;
  logic              last_q, last_d;
  logic [D2_W-1:0]   d2_q, d2_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic signed [FORCE_W-1:0] sumx_q, sumx_d, sumy_q, sumy_d;
  logic              sat_q, sat_d, coin_q, coin_d;
  logic              ov_q, ov_d;
  logic signed [FORCE_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic              osat_q, osat_d, ocoin_q, ocoin_d;

  logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_sub, alu_carry;
  logic signed [DIFF_W-1:0] dx, dy;
  logic              neg;
  logic [QUO_W-1:0]  limit, qm;
  logic signed [FORCE_W:0]   trm;
  logic signed [FORCE_W+1:0] nsum;
  logic signed [FORCE_W-1:0] csum;
  logic              nsat;

  pfrf_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .res_o  (alu_res),
    .carry_o(alu_carry)
  );

  assign dx = DIFF_W'(obs_i.vehicle_x) - DIFF_W'($signed({obs_i.obstacle_x, 8'b0}));
  assign dy = DIFF_W'(obs_i.vehicle_y) - DIFF_W'($signed({obs_i.obstacle_y, 8'b0}));
  assign rb = res_q + bit_q;

  assign obs_i.ready              = (state_q == ST_IDLE);
  assign force_o.valid            = ov_q;
  assign force_o.force_x          = ox_q;
  assign force_o.force_y          = oy_q;
  assign force_o.force_saturated  = osat_q;
  assign force_o.zero_distance_seen = ocoin_q;

  always_comb begin
    neg   = comp_q ? negy_q : negx_q;
    limit = neg ? QUO_W'(33'h080000000) : QUO_W'(33'h07FFFFFFF);
    nsat  = (quo_q > limit);
    qm    = nsat ? limit : quo_q;
    trm   = neg ? -$signed({1'b0, qm[FORCE_W-1:0]}) : $signed({1'b0, qm[FORCE_W-1:0]});
    nsum  = (comp_q ? {{2{sumy_q[FORCE_W-1]}}, sumy_q} : {{2{sumx_q[FORCE_W-1]}}, sumx_q})
            + {trm[FORCE_W], trm};
    if (nsum > $signed({3'b000, {(FORCE_W-1){1'b1}}})) begin
      csum = {1'b0, {(FORCE_W-1){1'b1}}};
    end else if (nsum < $signed({3'b111, {(FORCE_W-1){1'b0}}})) begin
      csum = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      csum = nsum[FORCE_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    acc_d = acc_q; ma_d = ma_q; mb_d = mb_q;
    res_d = res_q; bit_d = bit_q;
    magx_d = magx_q; magy_d = magy_q; negx_d = negx_q; negy_d = negy_q;
    d_d = d_q; d2_d = d2_q; den_d = den_q; base_d = base_q;
    quo_d = quo_q; cnt_d = cnt_q; comp_d = comp_q; last_d = last_q;
    sumx_d = sumx_q; sumy_d = sumy_q; sat_d = sat_q; coin_d = coin_q;
    ov_d = ov_q; ox_d = ox_q; oy_d = oy_q; osat_d = osat_q; ocoin_d = ocoin_q;
    alu_a = acc_q;
    alu_b = ma_q;
    alu_sub = 1'b0;

    if (ov_q && force_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (obs_i.valid) begin
          last_d = obs_i.final_obstacle;
          negx_d = dx[DIFF_W-1];
          negy_d = dy[DIFF_W-1];
          magx_d = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
          magy_d = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
          acc_d = '0;
          ma_d = ALU_W'(magx_d);
          mb_d = MULB_W'(magx_d);
          state_d = obs_i.obstacle_present ? ST_SQX : ST_FIN;
        end
      end
      ST_SQX, ST_SQY, ST_D2, ST_RD2, ST_DEN, ST_BASE, ST_NUM: begin
        if (mb_q != '0) begin
          if (mb_q[0]) begin
            acc_d = alu_res;
          end
          ma_d = ma_q << 1;
          mb_d = mb_q >> 1;
        end else begin
          case (state_q)
            ST_SQX: begin
              ma_d = ALU_W'(magy_q);
              mb_d = MULB_W'(magy_q);
              state_d = ST_SQY;
            end
            ST_SQY: begin
              res_d = '0;
              bit_d = ROOT_W'(1) << (ROOT_W - 1);
              state_d = ST_SQRT;
            end
            ST_D2: begin
              d2_d = acc_q[D2_W-1:0];
              ma_d = acc_q;
              mb_d = MULB_W'(cfg_i.radius);
              acc_d = '0;
              state_d = ST_RD2;
            end
            ST_RD2: begin
              ma_d = acc_q;
              mb_d = d2_q;
              acc_d = '0;
              state_d = ST_DEN;
            end
            ST_DEN: begin
              den_d = acc_q[DEN_W-1:0];
              ma_d = ALU_W'(cfg_i.gain);
              mb_d = MULB_W'(cfg_i.radius - d_q[RAD_W-1:0]);
              acc_d = '0;
              state_d = ST_BASE;
            end
            ST_BASE: begin
              base_d = acc_q[BASE_W-1:0];
              comp_d = 1'b0;
              ma_d = acc_q;
              mb_d = MULB_W'(magx_q);
              acc_d = '0;
              state_d = ST_NUM;
            end
            default: begin
              acc_d = acc_q << NUM_SH;
              ma_d = ALU_W'(den_q) << DIV_SH;
              quo_d = '0;
              cnt_d = CNT_W'(DIV_SH);
              state_d = ST_DIV;
            end
          endcase
        end
      end
      ST_SQRT: begin
        alu_b = ALU_W'(rb);
        alu_sub = 1'b1;
        if (bit_q == '0) begin
          d_d = res_q[DIFF_W-1:0];
          state_d = ST_CHK;
        end else begin
          if (alu_carry) begin
            acc_d = alu_res;
            res_d = (res_q >> 1) + bit_q;
          end else begin
            res_d = res_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end
      ST_CHK: begin
        if (d_q == '0) begin
          coin_d = 1'b1;
          state_d = ST_FIN;
        end else if (d_q > DIFF_W'(cfg_i.radius)) begin
          state_d = ST_FIN;
        end else begin
          ma_d = ALU_W'(d_q);
          mb_d = MULB_W'(d_q);
          acc_d = '0;
          state_d = ST_D2;
        end
      end
      ST_DIV: begin
        alu_sub = 1'b1;
        if (alu_carry) begin
          acc_d = alu_res;
          quo_d = {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[QUO_W-2:0], 1'b0};
        end
        ma_d = ma_q >> 1;
        if (cnt_q == '0) begin
          state_d = ST_TERM;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_TERM: begin
        if (nsat || (nsum != {{2{csum[FORCE_W-1]}}, csum})) begin
          sat_d = 1'b1;
        end
        if (comp_q) begin
          sumy_d = csum;
          state_d = ST_FIN;
        end else begin
          sumx_d = csum;
          comp_d = 1'b1;
          ma_d = ALU_W'(base_q);
          mb_d = MULB_W'(magy_q);
          acc_d = '0;
          state_d = ST_NUM;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!ov_q || force_o.ready) begin
          ov_d = 1'b1;
          ox_d = sumx_q;
          oy_d = sumy_q;
          osat_d = sat_q;
          ocoin_d = coin_q;
          sumx_d = '0;
          sumy_d = '0;
          sat_d = 1'b0;
          coin_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sumx_q <= '0;
      sumy_q <= '0;
      sat_q <= 1'b0;
      coin_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sumx_q <= sumx_d;
      sumy_q <= sumy_d;
      sat_q <= sat_d;
      coin_q <= coin_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; ma_q <= ma_d; mb_q <= mb_d;
    res_q <= res_d; bit_q <= bit_d;
    magx_q <= magx_d; magy_q <= magy_d; negx_q <= negx_d; negy_q <= negy_d;
    d_q <= d_d; d2_q <= d2_d; den_q <= den_d; base_q <= base_d;
    quo_q <= quo_d; cnt_q <= cnt_d; comp_q <= comp_d; last_q <= last_d;
    ox_q <= ox_d; oy_q <= oy_d; osat_q <= osat_d; ocoin_q <= ocoin_d;
  end
endmodule
`default_nettype wire

FILE: rtl/potential_field_repulsive_force_unit.sv
`default_nettype none
// Repulsive force accumulator for a potential field planner. Each obstacle
// transfer carries the vehicle position and at most one obstacle; the force
// sums come out in one transfer on the item flagged as final, after which the
// sums and flags clear. The squares, products, distance root and 35-bit
// quotient all run on one shared 136-bit add/subtract unit: products by
// shift-and-add over the multiplier bits, the root bit by bit and the
// quotient by restoring division. An item without an obstacle, or with one
// at zero distance or outside the radius, adds no force term. The block
// accepts no item until the current one is done. Configuration registers
// should be written only while no obstacle is being processed.
module potential_field_repulsive_force_unit (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pfrf_cfg_if.sink     cfg_i,
  pfrf_obs_if.sink     obs_i,
  pfrf_force_if.source force_o
);
  import pfrf_pkg::*;

  pfrf_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (pfrf_cfg_e'(cfg_i.index))
        CFG_GAIN:   cfg_d.gain = cfg_i.data;
        CFG_RADIUS: cfg_d.radius = cfg_i.data[RAD_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain <= GAIN_W'(65536);
      cfg_q.radius <= RAD_W'(2560);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pfrf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .obs_i  (obs_i),
    .force_o(force_o)
  );
endmodule
`default_nettype wire

FILE: tb/tb_potential_field_repulsive_force_unit.sv
`default_nettype none
module tb_potential_field_repulsive_force_unit;
  import pfrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 8000000;
  localparam int unsigned DRAIN_CYCLES = 700;
  localparam int unsigned ITEMS_PER_PHASE = 270;
  localparam int unsigned NUM_PHASES = 6;

  typedef struct {
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic signed [OBS_W-1:0] ox;
    logic signed [OBS_W-1:0] oy;
    bit                      pres;
    bit                      fin;
  } obstacle_item_t;

  typedef struct {
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
    bit                        sat;
    bit                        zero;
  } force_sum_t;

  typedef struct {
    bit             cfg;
    logic [31:0]    gain;
    logic [19:0]    radius;
    obstacle_item_t item;
    bit             typed;
    force_sum_t     want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfrf_cfg_if   cfg();
  pfrf_obs_if   obs();
  pfrf_force_if frc();

  potential_field_repulsive_force_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg),
    .obs_i   (obs),
    .force_o (frc)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [GAIN_W-1:0] mdl_gain;
  logic [RAD_W-1:0]  mdl_radius;
  longint            acc_x;
  longint            acc_y;
  bit                acc_sat;
  bit                acc_zero;

  force_sum_t        force_q[$];
  directed_row_t     rows[$];
  int unsigned       mismatches = 0;
  int unsigned       items_sent = 0;
  int unsigned       forces_seen = 0;
  int unsigned       cfg_writes = 0;
  int unsigned       cycles = 0;
  int unsigned       hold_left = 0;
  int unsigned       stall_left = 0;
  bit                hold_done = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_sum(longint v);
    if (v > 64'sd2147483647) begin
      acc_sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      acc_sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint repel_term(longint diff, longint unsigned d);
    logic [135:0]    num;
    logic [135:0]    den;
    logic [135:0]    q;
    longint unsigned mag;
    longint unsigned lim;
    longint unsigned rmd;
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    lim = (diff < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
    rmd = longint'(mdl_radius) - d;
    num = (136'(mdl_gain) * 136'(rmd) * 136'(mag)) << (FORCE_FRAC_BITS + 8);
    den = 136'(mdl_radius) * 136'(d * d) * 136'(d * d);
    q = num / den;
    if (q > 136'(lim)) begin
      acc_sat = 1'b1;
      q = 136'(lim);
    end
    return (diff < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic bit apply_obstacle(obstacle_item_t it, output force_sum_t r);
    longint          dx;
    longint          dy;
    longint unsigned d;
    longint          tx;
    longint          ty;
    r = '{default: '0};
    if (it.pres) begin
      dx = longint'(it.vx) - longint'(it.ox) * 256;
      dy = longint'(it.vy) - longint'(it.oy) * 256;
      d = int_sqrt(longint'(dx * dx + dy * dy));
      if (d == 0) begin
        acc_zero = 1'b1;
      end else if (d <= longint'(mdl_radius)) begin
        tx = repel_term(dx, d);
        ty = repel_term(dy, d);
        acc_x = clamp_sum(acc_x + tx);
        acc_y = clamp_sum(acc_y + ty);
      end
    end
    if (!it.fin) return 1'b0;
    r.fx = acc_x[31:0];
    r.fy = acc_y[31:0];
    r.sat = acc_sat;
    r.zero = acc_zero;
    acc_x = 0;
    acc_y = 0;
    acc_sat = 1'b0;
    acc_zero = 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("[%0t] force %0d: %s got %0d expected %0d", $realtime, forces_seen, what, got,
             want);
    mismatches++;
  endtask

  task automatic write_reg(pfrf_cfg_e idx, logic [31:0] data);
    @(negedge clk);
    obs.valid = 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = data;
    do @(posedge clk); while (!cfg.ready);
    if (idx == CFG_GAIN) mdl_gain = data;
    else mdl_radius = data[RAD_W-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic send_item(obstacle_item_t it, bit typed, force_sum_t want);
    force_sum_t  pred;
    int unsigned g;
    @(negedge clk);
    obs.valid = 1'b1;
    obs.vehicle_x = it.vx;
    obs.vehicle_y = it.vy;
    obs.obstacle_x = it.ox;
    obs.obstacle_y = it.oy;
    obs.obstacle_present = it.pres;
    obs.final_obstacle = it.fin;
    do @(posedge clk); while (!obs.ready);
    items_sent++;
    if (apply_obstacle(it, pred)) force_q.push_back(typed ? want : pred);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      obs.valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  function automatic obstacle_item_t mk(int vx, int vy, int ox, int oy, bit p, bit f);
    obstacle_item_t it;
    it.vx = POS_W'(vx);
    it.vy = POS_W'(vy);
    it.ox = OBS_W'(ox);
    it.oy = OBS_W'(oy);
    it.pres = p;
    it.fin = f;
    return it;
  endfunction

  task automatic add_row(bit c, logic [31:0] g, logic [19:0] r, obstacle_item_t it, bit typed,
                         longint fx, longint fy, bit s, bit z);
    directed_row_t row;
    row.cfg = c;
    row.gain = g;
    row.radius = r;
    row.item = it;
    row.typed = typed;
    row.want.fx = fx[31:0];
    row.want.fy = fy[31:0];
    row.want.sat = s;
    row.want.zero = z;
    rows.push_back(row);
  endtask

  function automatic obstacle_item_t rand_list_item(int base_x, int base_y, int spread,
                                                    logic signed [POS_W-1:0] vx,
                                                    logic signed [POS_W-1:0] vy, bit f);
    int ox;
    int oy;
    ox = base_x + int'($urandom_range(0, 2 * spread)) - spread;
    oy = base_y + int'($urandom_range(0, 2 * spread)) - spread;
    if (ox > 2047) ox = 2047;
    if (ox < -2048) ox = -2048;
    if (oy > 2047) oy = 2047;
    if (oy < -2048) oy = -2048;
    return mk(vx, vy, ox, oy, ($urandom_range(0, 99) < 88), f);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      frc.ready = 1'b0;
    end else if (hold_left > 0) begin
      frc.ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      frc.ready = 1'b0;
      stall_left--;
    end else begin
      frc.ready = 1'b1;
      stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    force_sum_t w;
    if (rst_n && frc.valid && frc.ready) begin
      forces_seen++;
      if (force_q.size() == 0) begin
        report("unexpected transfer, force_x", frc.force_x, 0);
      end else begin
        w = force_q.pop_front();
        if (frc.force_x !== w.fx) report("force_x", frc.force_x, w.fx);
        if (frc.force_y !== w.fy) report("force_y", frc.force_y, w.fy);
        if (frc.force_saturated !== w.sat) report("force_saturated", frc.force_saturated, w.sat);
        if (frc.zero_distance_seen !== w.zero)
          report("zero_distance_seen", frc.zero_distance_seen, w.zero);
      end
      if (forces_seen == 20 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 6000;
      end
    end
  end

  initial begin
    obstacle_item_t it;
    force_sum_t     none;
    int unsigned    n;
    int unsigned    len;
    int             spread;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic [31:0]    g;
    logic [19:0]    r;

    cfg.valid = 1'b0;
    cfg.index = CFG_GAIN;
    cfg.data = '0;
    obs.valid = 1'b0;
    obs.vehicle_x = '0;
    obs.vehicle_y = '0;
    obs.obstacle_x = '0;
    obs.obstacle_y = '0;
    obs.obstacle_present = 1'b0;
    obs.final_obstacle = 1'b0;
    none = '{default: '0};

    mdl_gain = 32'd65536;
    mdl_radius = 20'd2560;
    acc_x = 0;
    acc_y = 0;
    acc_sat = 1'b0;
    acc_zero = 1'b0;

    add_row(0, 0, 0, mk(0, 0, 0, 0, 0, 1), 1, 0, 0, 0, 0);
    add_row(0, 0, 0, mk(1280, -768, 5, -3, 1, 1), 1, 0, 0, 0, 1);
    add_row(0, 0, 0, mk(0, 0, 100, 0, 1, 1), 1, 0, 0, 0, 0);
    add_row(0, 0, 0, mk(0, 0, 3, 4, 1, 0), 0, 0, 0, 0, 0);
    add_row(0, 0, 0, mk(0, 0, -2, 1, 1, 0), 0, 0, 0, 0, 0);
    add_row(0, 0, 0, mk(100, -50, 0, 0, 0, 1), 0, 0, 0, 0, 0);
    add_row(1, 32'hFFFF_FFFF, 20'hFFFFF, mk(1, 0, 0, 0, 1, 1), 1, 64'sd2147483647, 0, 1, 0);
    add_row(0, 0, 0, mk(-1, 0, 0, 0, 1, 1), 1, -64'sd2147483648, 0, 1, 0);
    add_row(0, 0, 0, mk(-524288, 524287, 2047, -2048, 1, 1), 0, 0, 0, 0, 0);
    add_row(0, 0, 0, mk(524287, -524288, -2048, 2047, 1, 0), 0, 0, 0, 0, 0);
    add_row(0, 0, 0, mk(524287, 524287, 2047, 2047, 1, 1), 0, 0, 0, 0, 0);
    add_row(0, 0, 0, mk(-524288, -524288, -2048, -2048, 1, 1), 0, 0, 0, 0, 0);
    add_row(1, 32'd0, 20'd1, mk(1, 0, 0, 0, 1, 1), 1, 0, 0, 0, 0);
    add_row(1, 32'd65536, 20'd2560, mk(2000, 300, 5, 0, 1, 0), 0, 0, 0, 0, 0);
    add_row(0, 0, 0, mk(2000, 300, 9, 3, 1, 0), 0, 0, 0, 0, 0);
    add_row(0, 0, 0, mk(2000, 300, 8, 1, 1, 1), 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].cfg) begin
        write_reg(CFG_GAIN, rows[i].gain);
        write_reg(CFG_RADIUS, 32'(rows[i].radius));
      end
      send_item(rows[i].item, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin g = 32'd65536; r = 20'd2560; end
        1: begin g = 32'hFFFF_FFFF; r = 20'hFFFFF; end
        2: begin g = $urandom; r = RAD_W'($urandom_range(1, 20'hFFFFF)); end
        3: begin g = $urandom; r = RAD_W'($urandom_range(1, 300)); end
        4: begin g = $urandom_range(0, 32'h0010_0000); r = 20'hFFFFF; end
        default: begin g = 32'd65536; r = 20'd2560; end
      endcase
      write_reg(CFG_GAIN, g);
      write_reg(CFG_RADIUS, 32'(r));
      spread = int'(mdl_radius) / 256 + 2;
      if (spread > 2000) spread = 2000;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 12) begin
          it = mk($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                  $urandom_range(0, 1));
          send_item(it, 0, none);
          n++;
        end else begin
          len = $urandom_range(1, 6);
          vx = POS_W'($urandom);
          vy = POS_W'($urandom);
          for (int k = 0; k < len; k++) begin
            it = rand_list_item(int'(vx) >>> 8, int'(vy) >>> 8, spread, vx, vy, k == len - 1);
            if ($urandom_range(0, 99) < 5) it.ox = OBS_W'(it.vx >>> 8);
            if ($urandom_range(0, 99) < 5) begin
              it.vx = {it.ox, 8'h00};
              it.vy = {it.oy, 8'h00};
            end
            send_item(it, 0, none);
            n++;
          end
        end
      end
    end

    @(negedge clk);
    obs.valid = 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d obstacle items over %0d register writes; %0d force sums checked.",
             items_sent, cfg_writes, forces_seen);
    $display("Settings ranged from zero gain and unit radius to full-scale gain and radius.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/pfrf_pkg.sv
rtl/pfrf_if.sv
rtl/pfrf_alu.sv
rtl/pfrf_core.sv
rtl/potential_field_repulsive_force_unit.sv
tb/tb_potential_field_repulsive_force_unit.sv
